// ----- sv/xdbt_pkg.sv -----
// Package with shared types and constants of the bucket table.
package xdbt_pkg;

    localparam int unsigned IdWidthDef       = 64;
    localparam int unsigned BucketSlotsDef   = 8;
    localparam int unsigned EndpointWidthDef = 48;
    localparam int unsigned MaxFoundDef      = 64;

    localparam int unsigned IdW    = 64;
    localparam int unsigned EpW    = 48;
    localparam int unsigned CountW = 7;
    localparam int unsigned CapW   = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic {
        KIND_STATUS   = 1'b0,
        KIND_NEIGHBOR = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_OWN_ID   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_opcode           opcode;
        logic [IdW-1:0]    node_id;
        logic [EpW-1:0]    endpoint;
        logic [CountW-1:0] count_wanted;
    } t_in_item;

    typedef struct packed {
        t_kind          result_kind;
        logic           status;
        logic [IdW-1:0] found_id;
        logic [EpW-1:0] found_endpoint;
        logic           last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_CMP,
        ST_ADD_DONE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FIND_REQ,
        ST_FIND_CMP,
        ST_FIND_EMIT,
        ST_FIND_RD,
        ST_FIND_OUT
    } t_state;

endpackage

// ----- sv/xdbt_front.sv -----
// Front end: accepts items, computes the bucket number and queues classified commands.
module xdbt_front #(
    parameter int unsigned ID_WIDTH     = xdbt_pkg::IdWidthDef,
    parameter int unsigned MAX_FOUND    = xdbt_pkg::MaxFoundDef,
    parameter int unsigned BKT_W        = (ID_WIDTH > 1) ? $clog2(ID_WIDTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  xdbt_pkg::t_in_item        i_item,
    input  logic [ID_WIDTH-1:0]       i_own_id,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_pop,
    output xdbt_pkg::t_in_item        o_cmd,
    output logic [BKT_W-1:0]          o_cmd_bucket,
    output logic                      o_cmd_self
);
    import xdbt_pkg::*;

    localparam int unsigned QD = 2;

    t_in_item         r_q_item   [QD];
    logic [BKT_W-1:0] r_q_bucket [QD];
    logic             r_q_self   [QD];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    logic [ID_WIDTH-1:0] w_dist;
    logic [BKT_W-1:0]    w_bucket;
    logic                w_push, w_pop;
    t_in_item            w_item;

    // Bucket number is the leading zero count of the distance within ID_WIDTH bits.
    always_comb begin
        w_dist   = i_item.node_id[ID_WIDTH-1:0] ^ i_own_id;
        w_bucket = '0;
        for (int i = 0; i < ID_WIDTH; i++) begin
            if (w_dist[i]) begin
                w_bucket = BKT_W'(ID_WIDTH - 1 - i);
            end
        end
    end

    always_comb begin
        w_item = i_item;
        w_item.node_id = IdW'(i_item.node_id[ID_WIDTH-1:0]);
        if (i_item.count_wanted > CountW'(MAX_FOUND)) begin
            w_item.count_wanted = CountW'(MAX_FOUND);
        end
    end

    assign o_full      = (r_cnt == 2'(QD));
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    assign o_cmd        = r_q_item[r_rp];
    assign o_cmd_bucket = r_q_bucket[r_rp];
    assign o_cmd_self   = r_q_self[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_item[r_wp]   <= w_item;
            r_q_bucket[r_wp] <= w_bucket;
            r_q_self[r_wp]   <= (w_dist == '0);
        end
    end

endmodule

// ----- sv/xdbt_back.sv -----
// Back end: executes add, remove and find on the slot memory and emits results.
module xdbt_back #(
    parameter int unsigned ID_WIDTH       = xdbt_pkg::IdWidthDef,
    parameter int unsigned BUCKET_SLOTS   = xdbt_pkg::BucketSlotsDef,
    parameter int unsigned ENDPOINT_WIDTH = xdbt_pkg::EndpointWidthDef,
    parameter int unsigned BKT_W          = (ID_WIDTH > 1) ? $clog2(ID_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    input  xdbt_pkg::t_in_item    i_cmd,
    input  logic [BKT_W-1:0]      i_cmd_bucket,
    input  logic                  i_cmd_self,
    input  logic [3:0]            i_capacity,
    output logic                  o_empty,
    input  logic                  i_pop,
    output xdbt_pkg::t_out_item   o_result
);
    import xdbt_pkg::*;

    localparam int unsigned FILL_W = $clog2(BUCKET_SLOTS + 1);
    localparam int unsigned SLOTS  = ID_WIDTH * BUCKET_SLOTS;
    localparam int unsigned ADDR_W = $clog2(SLOTS);
    localparam int unsigned ID_HI  = ID_WIDTH - 1;

    // Slot memory and per-slot valid flags.
    logic [ID_WIDTH-1:0]       r_mem_id [SLOTS];
    logic [ENDPOINT_WIDTH-1:0] r_mem_ep [SLOTS];
    logic [SLOTS-1:0]          r_valid;
    logic [FILL_W-1:0]         r_fill [ID_WIDTH];

    t_state r_state, n_state;
    t_in_item          r_cmd;
    logic [BKT_W-1:0]  r_bkt;
    logic [FILL_W-1:0] r_cur_fill;
    logic [FILL_W-1:0] r_pos;
    logic [ADDR_W:0]   r_scan;
    logic [ADDR_W-1:0] r_best_s, r_prev_s;
    logic [ID_WIDTH-1:0] r_best_d, r_prev_d;
    logic              r_got, r_have_prev;
    logic [CountW-1:0] r_sent;
    logic [ID_WIDTH-1:0]       r_rd_id;
    logic [ENDPOINT_WIDTH-1:0] r_rd_ep;
    logic              r_rd_valid;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_status;
    // A found neighbor is held here until the next pass, or the reached count, shows whether it is the last one.
    logic [ID_WIDTH-1:0]       r_hold_id;
    logic [ENDPOINT_WIDTH-1:0] r_hold_ep;

    // Output register.
    t_out_item r_out;
    logic      r_out_full;

    logic [ADDR_W-1:0] w_base, w_rd_addr;
    logic              w_rd_en;
    logic [FILL_W-1:0] w_cap;
    logic [ID_WIDTH-1:0] w_d;
    logic              w_after, w_better, w_out_free, w_out_load;
    logic [ADDR_W-1:0] w_scan_s;

    assign w_base     = ADDR_W'(r_bkt) * ADDR_W'(BUCKET_SLOTS);
    assign w_out_free = !r_out_full || i_pop;
    assign w_out_load = w_out_free && ((r_state == ST_ADD_DONE) ||
                                       ((r_state == ST_FIND_OUT) && r_have_prev));
    assign o_empty    = !r_out_full;
    assign o_result   = r_out;
    assign w_scan_s   = r_scan[ADDR_W-1:0];

    always_comb begin
        if (i_capacity == 4'd0) begin
            w_cap = FILL_W'(1);
        end else if (32'(i_capacity) > BUCKET_SLOTS) begin
            w_cap = FILL_W'(BUCKET_SLOTS);
        end else begin
            w_cap = FILL_W'(i_capacity);
        end
    end

    // Find comparison against the registered read of the scanned slot.
    always_comb begin
        w_d      = r_rd_id ^ r_cmd.node_id[ID_HI:0];
        w_after  = !r_have_prev || (w_d > r_prev_d) ||
                   ((w_d == r_prev_d) && (r_rd_addr > r_prev_s));
        w_better = r_rd_valid && w_after && (!r_got || (w_d < r_best_d));
    end

    // Read address selection.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        case (r_state)
            ST_SCAN_REQ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_base + ADDR_W'(r_pos);
            end
            ST_SHIFT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_base + ADDR_W'(r_pos) + ADDR_W'(1);
            end
            ST_FIND_REQ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
            ST_FIND_CMP: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_scan_s;
            end
            ST_FIND_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_best_s;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_id   <= r_mem_id[w_rd_addr];
            r_rd_ep   <= r_mem_ep[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.opcode)
                        OP_ADD: n_state = i_cmd_self ? ST_ADD_DONE : ST_SCAN_REQ;
                        OP_REMOVE: n_state = i_cmd_self ? ST_IDLE : ST_SCAN_REQ;
                        OP_FIND: n_state = (i_cmd.count_wanted == '0) ? ST_IDLE
                                                                       : ST_FIND_REQ;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN_REQ: begin
                if (r_pos >= r_cur_fill) begin
                    n_state = (r_cmd.opcode == OP_ADD) ? ST_ADD_DONE : ST_IDLE;
                end else begin
                    n_state = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (r_rd_id == r_cmd.node_id[ID_HI:0]) begin
                    n_state = (r_cmd.opcode == OP_ADD) ? ST_ADD_DONE : ST_SHIFT_RD;
                end else begin
                    n_state = ST_SCAN_REQ;
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_ADD_DONE: if (w_out_free) n_state = ST_IDLE;
            ST_FIND_REQ: n_state = ST_FIND_CMP;
            ST_FIND_CMP: begin
                if (r_scan == (ADDR_W+1)'(SLOTS)) n_state = ST_FIND_EMIT;
            end
            ST_FIND_EMIT: n_state = r_got ? ST_FIND_RD : ST_FIND_OUT;
            ST_FIND_RD: n_state = ST_FIND_OUT;
            ST_FIND_OUT: begin
                // With the count reached the state stays here to send the held entry.
                if (!r_have_prev || w_out_free) begin
                    if (!r_got) begin
                        n_state = ST_IDLE;
                    end else if (r_sent + CountW'(1) != r_cmd.count_wanted) begin
                        n_state = ST_FIND_REQ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_SHIFT_RD &&
            (r_pos + FILL_W'(1) >= r_cur_fill)) begin
            n_state = ST_IDLE;
        end
    end

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // Datapath and outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_out_full <= 1'b0;
            r_rd_valid <= 1'b0;
            for (int b = 0; b < ID_WIDTH; b++) r_fill[b] <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_full <= 1'b1;
            end else if (i_pop && r_out_full) begin
                r_out_full <= 1'b0;
            end
            r_rd_valid <= w_rd_en ? r_valid[w_rd_addr] : r_rd_valid;
            case (r_state)
                ST_IDLE: begin
                    r_cmd       <= i_cmd;
                    r_bkt       <= i_cmd_bucket;
                    r_cur_fill  <= r_fill[i_cmd_bucket];
                    r_pos       <= '0;
                    r_status    <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_sent      <= '0;
                end
                ST_SCAN_REQ: begin
                    if (r_pos >= r_cur_fill && r_cmd.opcode == OP_ADD) begin
                        if (r_cur_fill >= w_cap) begin
                            r_status <= 1'b1;
                        end else begin
                            r_mem_id[w_base + ADDR_W'(r_cur_fill)] <=
                                r_cmd.node_id[ID_HI:0];
                            r_mem_ep[w_base + ADDR_W'(r_cur_fill)] <=
                                r_cmd.endpoint[ENDPOINT_WIDTH-1:0];
                            r_valid[w_base + ADDR_W'(r_cur_fill)] <= 1'b1;
                            r_fill[r_bkt] <= r_cur_fill + FILL_W'(1);
                        end
                    end
                end
                ST_SCAN_CMP: begin
                    if (r_rd_id == r_cmd.node_id[ID_HI:0]) begin
                        if (r_cmd.opcode == OP_ADD) begin
                            r_mem_ep[w_base + ADDR_W'(r_pos)] <=
                                r_cmd.endpoint[ENDPOINT_WIDTH-1:0];
                        end
                    end else begin
                        r_pos <= r_pos + FILL_W'(1);
                    end
                end
                ST_SHIFT_RD: begin
                    if (r_pos + FILL_W'(1) >= r_cur_fill) begin
                        r_valid[w_base + ADDR_W'(r_pos)] <= 1'b0;
                        r_fill[r_bkt] <= r_cur_fill - FILL_W'(1);
                    end
                end
                ST_SHIFT_WR: begin
                    r_mem_id[w_base + ADDR_W'(r_pos)] <= r_rd_id;
                    r_mem_ep[w_base + ADDR_W'(r_pos)] <= r_rd_ep;
                    r_pos <= r_pos + FILL_W'(1);
                end
                ST_ADD_DONE: begin
                    if (w_out_free) begin
                        r_out.result_kind    <= KIND_STATUS;
                        r_out.status         <= r_status;
                        r_out.found_id       <= '0;
                        r_out.found_endpoint <= '0;
                        r_out.last           <= 1'b1;
                    end
                end
                ST_FIND_REQ: begin
                    r_scan <= (ADDR_W+1)'(1);
                    r_got  <= 1'b0;
                end
                ST_FIND_CMP: begin
                    if (w_better) begin
                        r_got    <= 1'b1;
                        r_best_d <= w_d;
                        r_best_s <= r_rd_addr;
                    end
                    r_scan <= r_scan + (ADDR_W+1)'(1);
                end
                ST_FIND_OUT: begin
                    // The held entry is the last one when no further entry was found or the count was reached.
                    if (w_out_load) begin
                        r_out.result_kind    <= KIND_NEIGHBOR;
                        r_out.status         <= 1'b0;
                        r_out.found_id       <= IdW'(r_hold_id);
                        r_out.found_endpoint <= EpW'(r_hold_ep);
                        r_out.last           <= !r_got;
                    end
                    if (r_got && (!r_have_prev || w_out_free)) begin
                        r_hold_id   <= r_rd_id;
                        r_hold_ep   <= r_rd_ep;
                        r_sent      <= r_sent + CountW'(1);
                        r_have_prev <= 1'b1;
                        r_prev_d    <= r_best_d;
                        r_prev_s    <= r_best_s;
                        if (r_sent + CountW'(1) == r_cmd.count_wanted) begin
                            r_got <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- sv/xor_distance_bucket_table.sv -----
// Top level of the XOR distance bucket table.
// Add and remove read and compare one slot at a time; an item with the own id skips the scan.
// Remove then shifts the rest of the bucket down, one read and one write per slot.
// Find scans all slots once per result, plus a closing pass unless the count is reached.
// Only one command executes at a time; a two-entry queue decouples the input.
// Synchronous active-low reset empties the table, the queue and the output register.
module xor_distance_bucket_table #(
    parameter int unsigned ID_WIDTH       = xdbt_pkg::IdWidthDef,
    parameter int unsigned BUCKET_SLOTS   = xdbt_pkg::BucketSlotsDef,
    parameter int unsigned ENDPOINT_WIDTH = xdbt_pkg::EndpointWidthDef,
    parameter int unsigned MAX_FOUND      = xdbt_pkg::MaxFoundDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  xdbt_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output xdbt_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import xdbt_pkg::*;

    localparam int unsigned BKT_W = (ID_WIDTH > 1) ? $clog2(ID_WIDTH) : 1;

    logic [ID_WIDTH-1:0] r_own_id;
    logic [3:0]          r_capacity;

    logic             w_cmd_valid, w_cmd_pop, w_cmd_self;
    t_in_item         w_cmd;
    logic [BKT_W-1:0] w_cmd_bucket;

    // Config is always accepted; software writes must come only while idle (unchecked).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id   <= '0;
            r_capacity <= 4'd8;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_OWN_ID:   r_own_id   <= i_cfg_data[ID_WIDTH-1:0];
                CFG_CAPACITY: r_capacity <= i_cfg_data[3:0];
                default:      r_capacity <= r_capacity;
            endcase
        end
    end

    // The front end finds the bucket of each item and holds up to two items.
    xdbt_front #(
        .ID_WIDTH(ID_WIDTH),
        .MAX_FOUND(MAX_FOUND), .BKT_W(BKT_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full), .i_item(i_item), .i_own_id(r_own_id),
        .o_cmd_valid(w_cmd_valid), .i_cmd_pop(w_cmd_pop), .o_cmd(w_cmd),
        .o_cmd_bucket(w_cmd_bucket), .o_cmd_self(w_cmd_self)
    );

    // The back end owns the slot memory and the result register.
    xdbt_back #(
        .ID_WIDTH(ID_WIDTH), .BUCKET_SLOTS(BUCKET_SLOTS),
        .ENDPOINT_WIDTH(ENDPOINT_WIDTH), .BKT_W(BKT_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_pop(w_cmd_pop), .i_cmd(w_cmd),
        .i_cmd_bucket(w_cmd_bucket), .i_cmd_self(w_cmd_self),
        .i_capacity(r_capacity), .o_empty(empty), .i_pop(pop), .o_result(o_item)
    );

endmodule

// ----- sv/xdbt_checker.sv -----
// Port-level checker for the bucket table and its bind.
module xdbt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input xdbt_pkg::t_out_item o_item
);
    import xdbt_pkg::*;

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.result_kind == KIND_STATUS) |->
            (o_item.found_id == '0 && o_item.last))
        else $error("status result carries payload");

    a_neighbor_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.result_kind == KIND_NEIGHBOR) |-> !o_item.status)
        else $error("neighbor with status set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item.found_id)))
        else $error("waiting result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not empty after reset");

endmodule

bind xor_distance_bucket_table xdbt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty),
    .pop(pop), .o_item(o_item)
);
